// ----- hw/rtl/sfg_pkg.sv -----
// shared types, constants and helpers of the gravity flight unit
`default_nettype none
package sfg_pkg;

    localparam int CORDIC_N = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ORBIT_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORBIT_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORBIT_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORBIT_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DAYS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY  = 3'd7;

    localparam logic signed [63:0] VCAP = 64'sh0FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
    localparam logic signed [63:0] LAUNCH_OFFSET = 64'sd51539608;
    localparam logic [47:0] OUT_DIST_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [31:0] CAPTURE_RESET = 32'd32768;
    localparam logic [11:0] DAYS_RESET = 12'd600;
    localparam logic [31:0] GRAVITY_RESET = 32'd3271541874;

    localparam logic [29:0] ATAN_TURN [CORDIC_N] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163, 30'd81
    };

    typedef enum logic [4:0] {
        ST_IDLE, ST_L_SC, ST_L_PX, ST_L_PY, ST_H_SC, ST_H_VX, ST_H_VY,
        ST_DAY, ST_P_SC, ST_P_PX, ST_P_PY, ST_P_MAG, ST_P_MGS, ST_P_CHK,
        ST_P_DT, ST_P_DA, ST_P_DUX, ST_P_DUY, ST_P_AX, ST_P_AY, ST_P_NXT,
        ST_UPD_V, ST_UPD_S, ST_T_SC, ST_T_PX, ST_T_PY, ST_T_MAG, ST_T_MGS,
        ST_T_CHK, ST_FIN
    } t_state;

    typedef struct packed {
        logic              start;
        logic              vec;
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic [31:0]       ang;
    } t_cordic_req;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [5:0]  sh;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic              start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic              sh46;
    } t_mul_req;

    function automatic logic signed [63:0] sat60(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > VCAP) begin
            r = VCAP;
        end else if (v < -VCAP) begin
            r = -VCAP;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sfg_if.sv -----
// launch and result channel interfaces
`default_nettype none
interface sfg_launch_if;
    logic        valid;
    logic        ready;
    logic [1:0]  origin_slot;
    logic [31:0] launch_speed;
    logic [15:0] launch_heading;
    modport source(output valid, origin_slot, launch_speed, launch_heading, input ready);
    modport sink(input valid, origin_slot, launch_speed, launch_heading, output ready);
endinterface

interface sfg_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] flight_days;
    logic [47:0] closest_distance;
    logic        captured;
    modport source(output valid, flight_days, closest_distance, captured, input ready);
    modport sink(input valid, flight_days, closest_distance, captured, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sfg_cordic.sv -----
// iterative cordic, rotation for sine/cosine and vectoring for magnitude
`default_nettype none
module sfg_cordic (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfg_pkg::t_cordic_req i_req,
    output logic                 o_done,
    output logic signed [63:0]   o_x,
    output logic signed [63:0]   o_y
);
    import sfg_pkg::*;

    localparam logic [4:0] CNT_LAST = 5'(CORDIC_N - 1);

    logic               r_busy, r_done, r_vec;
    logic [4:0]         r_cnt;
    logic [1:0]         r_quad;
    logic signed [63:0] r_x, r_y, n_x, n_y, xs, ys;
    logic signed [33:0] r_z, n_z, atan;
    logic               dir;

    always_comb begin
        xs   = r_y >>> r_cnt;
        ys   = r_x >>> r_cnt;
        atan = $signed({4'b0000, ATAN_TURN[r_cnt]});
        dir  = r_vec ? r_y[63] : !r_z[33];
        if (dir) begin
            n_x = r_x - xs;
            n_y = r_y + ys;
            n_z = r_z - atan;
        end else begin
            n_x = r_x + xs;
            n_y = r_y - ys;
            n_z = r_z + atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_vec  <= i_req.vec;
            r_quad <= i_req.ang[31:30];
            if (i_req.vec) begin
                r_x <= i_req.x;
                r_y <= i_req.y;
                r_z <= '0;
            end else begin
                r_x <= CORDIC_GAIN;
                r_y <= '0;
                r_z <= $signed({4'b0000, i_req.ang[29:0]});
            end
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    // quadrant fold-back for rotation results
    always_comb begin
        if (r_vec) begin
            o_x = r_x;
            o_y = r_y;
        end else begin
            unique case (r_quad)
                2'd0: begin o_x = r_x;  o_y = r_y;  end
                2'd1: begin o_x = -r_y; o_y = r_x;  end
                2'd2: begin o_x = -r_x; o_y = -r_y; end
                default: begin o_x = r_y; o_y = -r_x; end
            endcase
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

// ----- hw/rtl/sfg_div.sv -----
// bit-serial restoring divider for (num << sh) / den with saturation
`default_nettype none
module sfg_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfg_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [63:0]       o_q
);
    import sfg_pkg::*;

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem, r_lo, r_q, r_den, start_rem, n_rem, n_q;
    logic [64:0] trial;

    always_comb begin
        start_rem = i_req.num >> (7'd64 - {1'b0, i_req.sh});
        trial     = {r_rem, r_lo[63]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = 64'(trial - {1'b0, r_den});
            n_q   = {r_q[62:0], 1'b1};
        end else begin
            n_rem = trial[63:0];
            n_q   = {r_q[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= '0;
                if (start_rem >= i_req.den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy && r_cnt == 6'd63) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= start_rem;
            r_lo  <= i_req.num << i_req.sh;
            r_den <= i_req.den;
            r_q   <= (start_rem >= i_req.den) ? 64'(VCAP) : 64'd0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[62:0], 1'b0};
            if (r_cnt == 6'd63 && n_q > 64'(VCAP)) begin
                r_q <= 64'(VCAP);
            end else begin
                r_q <= n_q;
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
endmodule
`default_nettype wire

// ----- hw/rtl/sfg_mul.sv -----
// signed 64x64 multiply from four 32x32 partials, shift and saturate
`default_nettype none
module sfg_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfg_pkg::t_mul_req  i_req,
    output logic               o_done,
    output logic signed [63:0] o_p
);
    import sfg_pkg::*;

    logic               r_busy, r_done, r_neg, r_sh46;
    logic [2:0]         r_cnt;
    logic [63:0]        r_ma, r_mb, prod, mag;
    logic [127:0]       r_acc, part, shifted;
    logic [31:0]        ah, bh;
    logic [1:0]         off;
    logic signed [63:0] r_p;

    always_comb begin
        ah      = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        bh      = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        prod    = ah * bh;
        off     = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
        part    = {64'd0, prod} << {off, 5'd0};
        shifted = r_sh46 ? (r_acc >> 46) : (r_acc >> 30);
        mag     = (shifted > 128'(VCAP)) ? 64'(VCAP) : shifted[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && r_cnt == 3'd4) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma   <= abs64(i_req.a);
            r_mb   <= abs64(i_req.b);
            r_neg  <= i_req.a[63] ^ i_req.b[63];
            r_sh46 <= i_req.sh46;
            r_acc  <= '0;
        end else if (r_busy && r_cnt != 3'd4) begin
            r_acc <= r_acc + part;
        end else if (r_busy) begin
            r_p <= r_neg ? -$signed(mag) : $signed(mag);
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;
endmodule
`default_nettype wire

// ----- hw/rtl/satellite_flight_gravity_sim_unit.sv -----
// satellite flight under planetary gravity, sequenced over shared arithmetic units
// sequence: launch setup, then each simulated day steps every planet in turn, paced by
//   the 64-step serial divider (four divides per planet), the 24-step
//   cordic and the four-pass multiplier; a saturating divide or a planet at zero
//   distance shortens a day, and the result is registered at the end
// throughput: one item at a time; the next launch is taken once the result is registered
// reset: synchronous active-low, clears the sequencer and result valid and
//   loads the configuration registers with their defaults
`default_nettype none
module satellite_flight_gravity_sim_unit #(
    parameter int PLANET_COUNT = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sfg_launch_if.sink                     i_launch,
    sfg_result_if.source                   o_result
);
    import sfg_pkg::*;

    localparam int K_W = (PLANET_COUNT > 1) ? $clog2(PLANET_COUNT) : 1;

    // configuration
    logic [63:0] r_orbit [4];
    logic [1:0]  r_target;
    logic [31:0] r_capture;
    logic [11:0] r_days;
    logic [31:0] r_gm;

    // sequencer
    t_state r_state, n_state;
    logic   r_issued;
    logic   use_cordic, use_div, use_mul, unit_done;

    // flight data
    logic [1:0]         r_origin;
    logic [35:0]        r_speed;
    logic [15:0]        r_heading;
    logic [11:0]        r_day;
    logic [K_W-1:0]     r_k;
    logic signed [63:0] r_c, r_s, r_sx, r_sy, r_vx, r_vy, r_ax, r_ay;
    logic signed [63:0] r_dx, r_dy, r_mag, r_ux, r_uy;
    logic [63:0]        r_d, r_t, r_a, r_best, best_min;
    logic               r_hit;

    // result register
    logic        r_out_valid, r_out_captured, out_load;
    logic [11:0] r_out_days;
    logic [47:0] r_out_closest;

    // unit hookup
    t_cordic_req        cor_req;
    t_div_req           div_req;
    t_mul_req           mul_req;
    logic               cor_done, div_done, mul_done;
    logic signed [63:0] cor_x, cor_y, mul_p;
    logic [63:0]        div_q;

    logic [1:0]         slot;
    logic [31:0]        phase;
    logic signed [63:0] radius, launch_r;

    sfg_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(cor_req),
        .o_done(cor_done), .o_x(cor_x), .o_y(cor_y)
    );

    sfg_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_q(div_q)
    );

    sfg_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req),
        .o_done(mul_done), .o_p(mul_p)
    );

    // configuration writes, unlisted indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_orbit[i] <= '0;
            end
            r_target  <= '0;
            r_capture <= CAPTURE_RESET;
            r_days    <= DAYS_RESET;
            r_gm      <= GRAVITY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORBIT_0, REG_ORBIT_1, REG_ORBIT_2, REG_ORBIT_3:
                    r_orbit[i_cfg_idx[1:0]] <= i_cfg_data;
                REG_TARGET:  r_target  <= i_cfg_data[1:0];
                REG_CAPTURE: r_capture <= i_cfg_data[31:0];
                REG_DAYS:    r_days    <= i_cfg_data[11:0];
                REG_GRAVITY: r_gm      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // planet slot in use, its orbit phase for the current day and radius
    always_comb begin
        unique case (r_state)
            ST_L_SC, ST_L_PX, ST_L_PY: slot = r_origin;
            ST_P_SC, ST_P_PX, ST_P_PY: slot = 2'(r_k);
            default:                   slot = r_target;
        endcase
        phase    = {r_orbit[slot][31:16], 16'h0000}
                 + 32'(r_day * r_orbit[slot][63:32]);
        radius   = $signed({22'd0, r_orbit[slot][15:0], 26'd0});
        launch_r = radius + LAUNCH_OFFSET;
        best_min = (r_d < r_best) ? r_d : r_best;
    end

    // which shared unit each state drives
    always_comb begin
        use_cordic = 1'b0;
        use_div    = 1'b0;
        use_mul    = 1'b0;
        unique case (r_state)
            ST_L_SC, ST_H_SC, ST_P_SC, ST_T_SC, ST_P_MAG, ST_T_MAG:
                use_cordic = 1'b1;
            ST_P_DT, ST_P_DA, ST_P_DUX, ST_P_DUY:
                use_div = 1'b1;
            ST_L_PX, ST_L_PY, ST_H_VX, ST_H_VY, ST_P_PX, ST_P_PY, ST_P_MGS,
            ST_T_PX, ST_T_PY, ST_T_MGS, ST_P_AX, ST_P_AY:
                use_mul = 1'b1;
            default: ;
        endcase
        unit_done = cor_done | div_done | mul_done;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_launch.valid) n_state = ST_L_SC;
            ST_L_SC:  if (unit_done) n_state = ST_L_PX;
            ST_L_PX:  if (unit_done) n_state = ST_L_PY;
            ST_L_PY:  if (unit_done) n_state = ST_H_SC;
            ST_H_SC:  if (unit_done) n_state = ST_H_VX;
            ST_H_VX:  if (unit_done) n_state = ST_H_VY;
            ST_H_VY:  if (unit_done) n_state = ST_DAY;
            ST_DAY:   n_state = (r_day >= r_days) ? ST_FIN : ST_P_SC;
            ST_P_SC:  if (unit_done) n_state = ST_P_PX;
            ST_P_PX:  if (unit_done) n_state = ST_P_PY;
            ST_P_PY:  if (unit_done) n_state = ST_P_MAG;
            ST_P_MAG: if (unit_done) n_state = ST_P_MGS;
            ST_P_MGS: if (unit_done) n_state = ST_P_CHK;
            ST_P_CHK: n_state = (r_d == 64'd0) ? ST_P_NXT : ST_P_DT;
            ST_P_DT:  if (unit_done) n_state = ST_P_DA;
            ST_P_DA:  if (unit_done) n_state = ST_P_DUX;
            ST_P_DUX: if (unit_done) n_state = ST_P_DUY;
            ST_P_DUY: if (unit_done) n_state = ST_P_AX;
            ST_P_AX:  if (unit_done) n_state = ST_P_AY;
            ST_P_AY:  if (unit_done) n_state = ST_P_NXT;
            ST_P_NXT: n_state = (r_k == K_W'(PLANET_COUNT - 1)) ? ST_UPD_V : ST_P_SC;
            ST_UPD_V: n_state = ST_UPD_S;
            ST_UPD_S: n_state = ST_T_SC;
            ST_T_SC:  if (unit_done) n_state = ST_T_PX;
            ST_T_PX:  if (unit_done) n_state = ST_T_PY;
            ST_T_PY:  if (unit_done) n_state = ST_T_MAG;
            ST_T_MAG: if (unit_done) n_state = ST_T_MGS;
            ST_T_MGS: if (unit_done) n_state = ST_T_CHK;
            ST_T_CHK: n_state = (best_min < {16'd0, r_capture, 16'd0}) ? ST_FIN : ST_DAY;
            ST_FIN:   if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // unit requests, each issued once on entering its state
    always_comb begin
        cor_req       = '0;
        div_req       = '0;
        mul_req       = '0;
        cor_req.start = use_cordic && !r_issued;
        div_req.start = use_div && !r_issued;
        mul_req.start = use_mul && !r_issued;
        cor_req.ang   = phase;
        cor_req.x     = $signed(abs64(r_dx));
        cor_req.y     = r_dy;
        div_req.den   = r_d;
        mul_req.b     = r_c;
        unique case (r_state)
            ST_H_SC:  cor_req.ang = {r_heading, 16'h0000};
            ST_P_MAG, ST_T_MAG: cor_req.vec = 1'b1;
            ST_L_PX:  mul_req.a = launch_r;
            ST_L_PY:  begin mul_req.a = launch_r; mul_req.b = r_s; end
            ST_H_VX:  mul_req.a = $signed({28'd0, r_speed});
            ST_H_VY:  begin mul_req.a = $signed({28'd0, r_speed}); mul_req.b = r_s; end
            ST_P_PX, ST_T_PX: mul_req.a = radius;
            ST_P_PY, ST_T_PY: begin mul_req.a = radius; mul_req.b = r_s; end
            ST_P_MGS, ST_T_MGS: begin mul_req.a = r_mag; mul_req.b = CORDIC_GAIN; end
            ST_P_AX:  begin mul_req.a = $signed(r_a); mul_req.b = r_ux; mul_req.sh46 = 1'b1; end
            ST_P_AY:  begin mul_req.a = $signed(r_a); mul_req.b = r_uy; mul_req.sh46 = 1'b1; end
            ST_P_DT:  begin div_req.num = {32'd0, r_gm}; div_req.sh = 6'd40; end
            ST_P_DA:  begin div_req.num = r_t; div_req.sh = 6'd32; end
            ST_P_DUX: begin div_req.num = abs64(r_dx); div_req.sh = 6'd30; end
            ST_P_DUY: begin div_req.num = abs64(r_dy); div_req.sh = 6'd30; end
            default: ;
        endcase
    end

    assign i_launch.ready = (r_state == ST_IDLE);
    assign out_load       = !r_out_valid || o_result.ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (unit_done) begin
                r_issued <= 1'b0;
            end else if (cor_req.start || div_req.start || mul_req.start) begin
                r_issued <= 1'b1;
            end
            if (r_state == ST_FIN && out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // flight datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_origin  <= i_launch.origin_slot;
                r_speed   <= {i_launch.launch_speed, 4'd0};
                r_heading <= i_launch.launch_heading;
                r_day     <= '0;
                r_best    <= '1;
                r_hit     <= 1'b0;
            end
            ST_L_SC, ST_H_SC, ST_P_SC, ST_T_SC: if (cor_done) begin
                r_c <= cor_x;
                r_s <= cor_y;
            end
            ST_L_PX: if (mul_done) r_sx <= mul_p;
            ST_L_PY: if (mul_done) r_sy <= mul_p;
            ST_H_VX: if (mul_done) r_vx <= mul_p;
            ST_H_VY: if (mul_done) r_vy <= mul_p;
            ST_DAY: begin
                r_ax <= '0;
                r_ay <= '0;
                r_k  <= '0;
            end
            ST_P_PX, ST_T_PX: if (mul_done) r_dx <= sat60(r_sx - mul_p);
            ST_P_PY, ST_T_PY: if (mul_done) r_dy <= sat60(r_sy - mul_p);
            ST_P_MAG, ST_T_MAG: if (cor_done) r_mag <= cor_x;
            ST_P_MGS, ST_T_MGS: if (mul_done) r_d <= 64'(mul_p);
            ST_P_DT:  if (div_done) r_t <= div_q;
            ST_P_DA:  if (div_done) r_a <= div_q;
            ST_P_DUX: if (div_done) r_ux <= r_dx[63] ? -$signed(div_q) : $signed(div_q);
            ST_P_DUY: if (div_done) r_uy <= r_dy[63] ? -$signed(div_q) : $signed(div_q);
            ST_P_AX:  if (mul_done) r_ax <= sat60(r_ax + mul_p);
            ST_P_AY:  if (mul_done) r_ay <= sat60(r_ay + mul_p);
            ST_P_NXT: r_k <= r_k + K_W'(1);
            ST_UPD_V: begin
                r_vx <= sat60(r_vx - r_ax);
                r_vy <= sat60(r_vy - r_ay);
            end
            ST_UPD_S: begin
                r_sx <= sat60(r_sx + r_vx);
                r_sy <= sat60(r_sy + r_vy);
            end
            ST_T_CHK: begin
                r_best <= best_min;
                if (best_min < {16'd0, r_capture, 16'd0}) begin
                    r_hit <= 1'b1;
                end else begin
                    r_day <= r_day + 12'd1;
                end
            end
            default: ;
        endcase
    end

    // result register, far distances saturate to the 48-bit field
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && out_load) begin
            r_out_days     <= r_day;
            r_out_closest  <= (r_best > 64'(OUT_DIST_MAX)) ? OUT_DIST_MAX : r_best[47:0];
            r_out_captured <= r_hit;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.flight_days      = r_out_days;
    assign o_result.closest_distance = r_out_closest;
    assign o_result.captured         = r_out_captured;

    // only one shared unit finishes at a time
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cor_done, div_done, mul_done}))
        else $error("more than one arithmetic unit done");

    // a capture result lies below the capture distance
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_captured) |-> (r_out_closest < {r_capture, 16'd0}))
        else $error("capture flagged above capture distance");

    // the reported day never passes the mission limit
    a_days: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_days <= r_days))
        else $error("flight days beyond mission limit");

    // a unit only finishes for a request the sequencer issued
    a_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_done |-> r_issued)
        else $error("unit done without a pending request");

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench of the gravity flight unit: directed table, random launches, reference prediction
`timescale 1ns / 1ps
module tb_top;
    import sfg_pkg::*;

    localparam int PLANETS = 4;
    localparam int SHOW_MAX = 10;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 50;
    localparam int HOLD_CYCLES = 3000;

    // one flight outcome as the block reports it
    typedef struct {
        logic [11:0] days;
        logic [47:0] closest;
        logic        hit;
    } flight_t;

    // a row of the directed table: the setting it runs under, the launch and,
    // where it can be read off directly, the outcome
    typedef struct {
        int          setting;
        logic [1:0]  origin;
        logic [31:0] speed;
        logic [15:0] heading;
        logic        typed;
        flight_t     outcome;
    } launch_row_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sfg_launch_if launch_ch();
    sfg_result_if result_ch();

    satellite_flight_gravity_sim_unit #(.PLANET_COUNT(PLANETS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_launch   (launch_ch),
        .o_result   (result_ch)
    );

    // mirror of the configuration registers, kept in step with every write
    logic [63:0] orbit_word [PLANETS];
    logic [1:0]  tgt_slot;
    logic [31:0] capture_q16;
    logic [11:0] day_limit;
    logic [31:0] gm_q40;

    flight_t pending_flights[$];
    int      mismatches;
    int      snd_idle;
    int      rcv_idle;
    int      hold_request;
    int      hold_left;
    int      quiet_cycles;

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------- arithmetic of the predictor ----------------

    // saturate to +-(2^60-1)
    function automatic logic signed [63:0] clamp60(input logic signed [63:0] v);
        if (v > VCAP) return VCAP;
        if (v < -VCAP) return -VCAP;
        return v;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // (a*b) >> sh with the magnitude truncated, saturated to +-VCAP
    function automatic logic signed [63:0] mul_shift(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh);
        logic [127:0] prod;
        logic [63:0]  m;
        logic         neg;
        neg = a[63] ^ b[63];
        prod = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        prod = prod >> sh;
        m = (prod > {64'd0, VCAP}) ? VCAP : prod[63:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // (n << sh) / d saturated to VCAP, d nonzero
    function automatic logic [63:0] div_shift(input logic [63:0] n, input int sh,
                                              input logic [63:0] d);
        logic [127:0] num;
        logic [127:0] q;
        if ((n >> (64 - sh)) >= d) return VCAP;
        num = {64'd0, n} << sh;
        q = num / {64'd0, d};
        return (q > {64'd0, VCAP}) ? VCAP : q[63:0];
    endfunction

    // rotation cordic on the low 30 bits, then quadrant fold
    task automatic sin_cos(input logic [31:0] ang, output logic signed [63:0] c,
                           output logic signed [63:0] s);
        logic signed [63:0] x, y, z, xs, ys;
        x = CORDIC_GAIN;
        y = 0;
        z = {34'd0, ang[29:0]};
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = y >>> i;
            ys = x >>> i;
            if (z >= 0) begin
                x = x - xs;
                y = y + ys;
                z = z - {34'd0, ATAN_TURN[i]};
            end else begin
                x = x + xs;
                y = y - ys;
                z = z + {34'd0, ATAN_TURN[i]};
            end
        end
        case (ang[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    // vectoring cordic, gain removed at the end
    function automatic logic [63:0] distance(input logic signed [63:0] dx,
                                             input logic signed [63:0] dy);
        logic signed [63:0] x, y, xs, ys;
        x = mag64(dx);
        y = dy;
        for (int i = 0; i < CORDIC_N; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
            end else begin
                x = x - ys;
                y = y + xs;
            end
        end
        return mul_shift(x, CORDIC_GAIN, 30);
    endfunction

    function automatic logic signed [63:0] radius_of(input int slot);
        return {22'd0, orbit_word[slot][15:0], 26'd0};
    endfunction

    function automatic logic [31:0] phase_of(input int slot, input logic [31:0] day);
        return {orbit_word[slot][31:16], 16'd0} + day * orbit_word[slot][63:32];
    endfunction

    task automatic planet_at(input int slot, input logic [31:0] day,
                             output logic signed [63:0] px, output logic signed [63:0] py);
        logic signed [63:0] c, s;
        sin_cos(phase_of(slot, day), c, s);
        px = mul_shift(radius_of(slot), c, 30);
        py = mul_shift(radius_of(slot), s, 30);
    endtask

    // full euler flight of one launch under the mirrored configuration
    task automatic predict_flight(input logic [1:0] origin, input logic [31:0] speed,
                                  input logic [15:0] heading, output flight_t res);
        logic signed [63:0] c, s, sx, sy, vx, vy, r, ax, ay, px, py, dx, dy, ux, uy;
        logic [63:0] best, cap, d, t, a;
        logic        hit;
        int          day;
        best = '1;
        cap = {16'd0, capture_q16, 16'd0};
        hit = 1'b0;
        r = radius_of(origin) + LAUNCH_OFFSET;
        sin_cos(phase_of(origin, 0), c, s);
        sx = mul_shift(r, c, 30);
        sy = mul_shift(r, s, 30);
        sin_cos({heading, 16'd0}, c, s);
        vx = mul_shift({28'd0, speed, 4'd0}, c, 30);
        vy = mul_shift({28'd0, speed, 4'd0}, s, 30);
        for (day = 0; day < int'(day_limit); day++) begin
            ax = 0;
            ay = 0;
            for (int k = 0; k < PLANETS; k++) begin
                planet_at(k, day, px, py);
                dx = clamp60(sx - px);
                dy = clamp60(sy - py);
                d = distance(dx, dy);
                // a planet sitting exactly on the satellite pulls nothing
                if (d != 0) begin
                    t = div_shift({32'd0, gm_q40}, 40, d);
                    a = div_shift(t, 32, d);
                    ux = div_shift(mag64(dx), 30, d);
                    uy = div_shift(mag64(dy), 30, d);
                    if (dx < 0) ux = -ux;
                    if (dy < 0) uy = -uy;
                    ax = clamp60(ax + mul_shift(a, ux, 46));
                    ay = clamp60(ay + mul_shift(a, uy, 46));
                end
            end
            vx = clamp60(vx - ax);
            vy = clamp60(vy - ay);
            sx = clamp60(sx + vx);
            sy = clamp60(sy + vy);
            planet_at(tgt_slot, day, px, py);
            d = distance(clamp60(sx - px), clamp60(sy - py));
            if (d < best) best = d;
            if (best < cap) begin
                hit = 1'b1;
                break;
            end
        end
        res.days = day[11:0];
        res.closest = (best > {16'd0, OUT_DIST_MAX}) ? OUT_DIST_MAX : best[47:0];
        res.hit = hit;
    endtask

    // ---------------- configuration ----------------

    // leaves the write enable high; the caller lowers it after its last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_ORBIT_0: orbit_word[0] = data;
            REG_ORBIT_1: orbit_word[1] = data;
            REG_ORBIT_2: orbit_word[2] = data;
            REG_ORBIT_3: orbit_word[3] = data;
            REG_TARGET:  tgt_slot = data[1:0];
            REG_CAPTURE: capture_q16 = data[31:0];
            REG_DAYS:    day_limit = data[11:0];
            default:     gm_q40 = data[31:0];
        endcase
    endtask

    // block is idle only once every launch has come back
    task automatic drain;
        while (pending_flights.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int which);
        drain();
        case (which)
            0: begin
                // only the day limit moves: zero days means no step at all
                write_reg(REG_DAYS, 64'd0);
            end
            1: begin
                // a small inner system, radii Q10.6, planet 0 steps about one orbit per year
                write_reg(REG_ORBIT_0, {32'd11767033, 16'h0000, 16'd64});
                write_reg(REG_ORBIT_1, {32'd6256395, 16'h4000, 16'd96});
                write_reg(REG_ORBIT_2, {32'd992166, 16'h8000, 16'd333});
                write_reg(REG_ORBIT_3, {32'd19107800, 16'hC000, 16'd46});
                write_reg(REG_TARGET, 64'd1);
                write_reg(REG_CAPTURE, 64'd32768);
                write_reg(REG_DAYS, 64'd4);
                write_reg(REG_GRAVITY, 64'd3271541874);
            end
            2: begin
                // slots 0 and 3 and the other settings at their top: capture is certain on the first day
                write_reg(REG_ORBIT_0, {32'hFFFF_FFFF, 16'h0000, 16'hFFFF});
                write_reg(REG_ORBIT_3, '1);
                write_reg(REG_TARGET, 64'd3);
                write_reg(REG_CAPTURE, 64'hFFFF_FFFF);
                write_reg(REG_DAYS, 64'd4095);
                write_reg(REG_GRAVITY, 64'hFFFF_FFFF);
            end
            3: begin
                // no gravity, no capture, planet 0 collapsed onto the sun
                write_reg(REG_ORBIT_0, 64'd0);
                write_reg(REG_TARGET, 64'd0);
                write_reg(REG_CAPTURE, 64'd0);
                write_reg(REG_DAYS, 64'd3);
                write_reg(REG_GRAVITY, 64'd0);
            end
            default: begin
                // random system, short missions keep the run bounded
                for (int k = 0; k < PLANETS; k++)
                    write_reg(CFG_IDX_W'(k), {$urandom, $urandom});
                write_reg(REG_TARGET, 64'($urandom_range(3, 0)));
                write_reg(REG_CAPTURE, $urandom_range(1, 0) ? 64'($urandom)
                                                          : 64'($urandom_range(1 << 20, 0)));
                write_reg(REG_DAYS, 64'($urandom_range(3, 1)));
                write_reg(REG_GRAVITY, $urandom_range(1, 0) ? 64'($urandom)
                                                          : 64'd3271541874);
            end
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------- launch side ----------------

    // offers one launch, holds it until taken, then records its predicted outcome
    task automatic send_launch(input logic [1:0] origin, input logic [31:0] speed,
                               input logic [15:0] heading, input logic typed,
                               input flight_t outcome);
        flight_t res;
        if (launch_ch.valid && ($urandom_range(99, 0) < snd_idle)) begin
            launch_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        while ($urandom_range(99, 0) < snd_idle) begin
            launch_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        launch_ch.valid <= 1'b1;
        launch_ch.origin_slot <= origin;
        launch_ch.launch_speed <= speed;
        launch_ch.launch_heading <= heading;
        do @(posedge i_clk); while (!launch_ch.ready);
        if (typed) begin
            res = outcome;
        end else begin
            predict_flight(origin, speed, heading, res);
        end
        pending_flights.push_back(res);
    endtask

    task automatic launch_done;
        launch_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------- result side, checking and watchdog ----------------

    always @(posedge i_clk) begin
        flight_t want;
        if (result_ch.valid && result_ch.ready) begin
            if (pending_flights.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result: days %0d dist %h captured %0b",
                             result_ch.flight_days, result_ch.closest_distance,
                             result_ch.captured);
            end else begin
                want = pending_flights.pop_front();
                if (want.days !== result_ch.flight_days
                        || want.closest !== result_ch.closest_distance
                        || want.hit !== result_ch.captured) begin
                    mismatches++;
                    if (mismatches <= SHOW_MAX)
                        $display("mismatch: days %0d/%0d dist %h/%h captured %0b/%0b (exp/act)",
                                 want.days, result_ch.flight_days, want.closest,
                                 result_ch.closest_distance, want.hit, result_ch.captured);
                end
            end
        end
        // long hold-off requested by the stimulus, so the block backs up
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99, 0) >= rcv_idle);
        end
        // watchdog on cycles where nothing moves
        if ((launch_ch.valid && launch_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- directed table ----------------

    localparam logic [47:0] FAR = 48'hFFFF_FFFF_FFFF;

    launch_row_t directed [] = '{
        // zero-day missions: nothing runs, distance saturated, never captured
        '{0, 2'd0, 32'd0,          16'h0000, 1'b1, '{12'd0, FAR, 1'b0}},
        '{0, 2'd3, 32'hFFFF_FFFF,  16'hFFFF, 1'b1, '{12'd0, FAR, 1'b0}},
        // inner system: every origin, speed and heading extremes, quadrant edges
        '{1, 2'd0, 32'd0,          16'h0000, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{1, 2'd1, 32'hFFFF_FFFF,  16'hFFFF, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{1, 2'd2, 32'h0100_0000,  16'h4000, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{1, 2'd3, 32'h0080_0000,  16'h8000, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{1, 2'd0, 32'h0800_0000,  16'hC000, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{1, 2'd1, 32'h8000_0000,  16'h3FFF, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{1, 2'd2, 32'h0000_0001,  16'h7FFF, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{1, 2'd3, 32'h5555_5555,  16'hAAAA, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{1, 2'd1, 32'hAAAA_AAAA,  16'h5555, 1'b0, '{12'd0, 48'd0, 1'b0}},
        // top-end system: launches mostly from a far orbit, capture on the first day
        '{2, 2'd0, 32'hFFFF_FFFF,  16'h0000, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{2, 2'd3, 32'd0,          16'hFFFF, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{2, 2'd1, 32'h1000_0000,  16'h8000, 1'b0, '{12'd0, 48'd0, 1'b0}},
        // no gravity, capture impossible; launching mostly from a planet at the center
        '{3, 2'd0, 32'd0,          16'h0000, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{3, 2'd0, 32'hFFFF_FFFF,  16'h2000, 1'b0, '{12'd0, 48'd0, 1'b0}},
        '{3, 2'd2, 32'h0400_0000,  16'hE000, 1'b0, '{12'd0, 48'd0, 1'b0}}
    };

    // ---------------- main sequence ----------------

    initial begin
        int          cur_setting;
        int          mode_snd [3];
        int          mode_rcv [3];
        logic [31:0] spd;
        flight_t     none;
        mode_snd = '{37, 58, 0};
        mode_rcv = '{58, 37, 0};
        none = '{12'd0, 48'd0, 1'b0};
        mismatches = 0;
        hold_request = 0;
        hold_left = 0;
        quiet_cycles = 0;
        snd_idle = mode_snd[0];
        rcv_idle = mode_rcv[0];
        // reset values of the mirror
        for (int k = 0; k < PLANETS; k++) orbit_word[k] = 64'd0;
        tgt_slot = 2'd0;
        capture_q16 = CAPTURE_RESET;
        day_limit = DAYS_RESET;
        gm_q40 = GRAVITY_RESET;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        launch_ch.valid = 1'b0;
        launch_ch.origin_slot = '0;
        launch_ch.launch_speed = '0;
        launch_ch.launch_heading = '0;
        result_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, one setting change whenever the table moves on
        cur_setting = -1;
        foreach (directed[r]) begin
            if (directed[r].setting != cur_setting) begin
                if (launch_ch.valid) launch_done();
                cur_setting = directed[r].setting;
                apply_setting(cur_setting);
            end
            send_launch(directed[r].origin, directed[r].speed, directed[r].heading,
                        directed[r].typed, directed[r].outcome);
        end
        launch_done();

        // random part in three idling modes, a fresh random system every 11 launches
        for (int m = 0; m < 3; m++) begin
            snd_idle = mode_snd[m];
            rcv_idle = mode_rcv[m];
            for (int n = 0; n < 33; n++) begin
                if (n % 11 == 0) begin
                    if (launch_ch.valid) launch_done();
                    apply_setting(4);
                    // receiver stalls for a long stretch while launches keep coming
                    if (m == 2 && n == 0) hold_request = HOLD_CYCLES;
                end
                // mostly modest speeds, now and then any 32-bit value
                spd = $urandom_range(3, 0) == 0 ? $urandom : $urandom_range(32'h0200_0000, 0);
                send_launch(2'($urandom_range(3, 0)), spd, 16'($urandom), 1'b0, none);
            end
        end
        launch_done();

        drain();
        if (mismatches == 0 && pending_flights.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sfg_pkg.sv
hw/rtl/sfg_if.sv
hw/rtl/sfg_cordic.sv
hw/rtl/sfg_div.sv
hw/rtl/sfg_mul.sv
hw/rtl/satellite_flight_gravity_sim_unit.sv
verif/tb_top.sv
